[rtl/pca_pkg.sv]
package pca_pkg;

  // Accumulation modes held in the mode register.
  typedef enum logic [1:0] {
    MODE_ALL_COS = 2'd0,
    MODE_XY_COS  = 2'd1,
    MODE_XY_VEV  = 2'd2,
    MODE_XY_SIN  = 2'd3
  } mode_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEV     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd2;

  localparam int LINK_W = 16;
  localparam int VEV_W  = 16;
  localparam int DIV_W  = 19;
  localparam int OUT_W  = 48;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Per-item control that travels with the angles through the queue.
  typedef struct packed {
    mode_t                    mode;
    logic                     last;
    logic signed [VEV_W-1:0]  vev;
  } pca_ctrl_t;

  // atan(2^-i) in units of 2^32 per turn.
  function automatic logic [29:0] atan_step(input logic [STEP_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/pca_if.sv]
interface pca_in_if;
  logic                        valid;
  logic                        ready;
  logic [pca_pkg::LINK_W-1:0]  x_link;
  logic [pca_pkg::LINK_W-1:0]  y_link;
  logic [pca_pkg::LINK_W-1:0]  t_link;
  logic [pca_pkg::LINK_W-1:0]  xn_y_link;
  logic [pca_pkg::LINK_W-1:0]  xn_t_link;
  logic [pca_pkg::LINK_W-1:0]  yn_x_link;
  logic [pca_pkg::LINK_W-1:0]  yn_t_link;
  logic [pca_pkg::LINK_W-1:0]  tn_x_link;
  logic [pca_pkg::LINK_W-1:0]  tn_y_link;
  logic                        is_last;

  modport source (
    output valid, x_link, y_link, t_link, xn_y_link, xn_t_link,
           yn_x_link, yn_t_link, tn_x_link, tn_y_link, is_last,
    input  ready
  );
  modport sink (
    input  valid, x_link, y_link, t_link, xn_y_link, xn_t_link,
           yn_x_link, yn_t_link, tn_x_link, tn_y_link, is_last,
    output ready
  );
endinterface

interface pca_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pca_pkg::OUT_W-1:0]  result_value;

  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

[rtl/pca_front.sv]
module pca_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  pca_in_if.sink                                 in_chan,
  input  pca_pkg::mode_t                         mode,
  input  logic signed [pca_pkg::VEV_W-1:0]       vev,
  output logic                                   q_valid,
  input  logic                                   q_pop,
  output logic [2:0][ANGLE_BITS-1:0]             q_angle,
  output pca_pkg::pca_ctrl_t                     q_ctrl
);

  logic [ANGLE_BITS-1:0] a_x, a_y, a_t, a_xny, a_xnt, a_ynx, a_ynt, a_tnx, a_tny;
  logic [2:0][ANGLE_BITS-1:0] plaq;
  pca_pkg::pca_ctrl_t ctrl_in;

  logic [2:0][ANGLE_BITS-1:0] ang_mem_r [pca_pkg::QUEUE_DEPTH];
  pca_pkg::pca_ctrl_t ctrl_mem_r [pca_pkg::QUEUE_DEPTH];
  logic [pca_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [pca_pkg::QPTR_W:0]   count_r, count_nxt;
  logic push, pop;

  // Plaquette angles wrap modulo a full turn by the width of the sums.
  always_comb begin
    a_x   = ANGLE_BITS'(in_chan.x_link);
    a_y   = ANGLE_BITS'(in_chan.y_link);
    a_t   = ANGLE_BITS'(in_chan.t_link);
    a_xny = ANGLE_BITS'(in_chan.xn_y_link);
    a_xnt = ANGLE_BITS'(in_chan.xn_t_link);
    a_ynx = ANGLE_BITS'(in_chan.yn_x_link);
    a_ynt = ANGLE_BITS'(in_chan.yn_t_link);
    a_tnx = ANGLE_BITS'(in_chan.tn_x_link);
    a_tny = ANGLE_BITS'(in_chan.tn_y_link);
    plaq[0] = a_x + a_xny - a_ynx - a_y;
    plaq[1] = a_x + a_xnt - a_tnx - a_t;
    plaq[2] = a_y + a_ynt - a_tny - a_t;
    ctrl_in.mode = mode;
    ctrl_in.last = in_chan.is_last;
    ctrl_in.vev  = vev;
  end

  assign in_chan.ready = (count_r != (pca_pkg::QPTR_W+1)'(pca_pkg::QUEUE_DEPTH));
  assign push    = in_chan.valid && in_chan.ready;
  assign q_valid = (count_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_angle = ang_mem_r[rd_ptr_r];
  assign q_ctrl  = ctrl_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ang_mem_r[wr_ptr_r]  <= plaq;
      ctrl_mem_r[wr_ptr_r] <= ctrl_in;
    end
  end

endmodule

[rtl/pca_cordic.sv]
module pca_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ANGLE_BITS-1:0]         angle,
  output logic                          done,
  output logic signed [FRAC_BITS+1:0]   cos_o,
  output logic signed [FRAC_BITS+1:0]   sin_o
);

  localparam int CW = pca_pkg::CORDIC_W;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [CW-1:0] HALF    = CW'(64'sd1 <<< (SH - 1));
  localparam logic signed [CW-1:0] ONE     = CW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [CW-1:0] NEG_ONE = -ONE;

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic [1:0] q_r;
  logic [pca_pkg::STEP_W-1:0] step_r;
  logic run_r, fin_r, done_r;
  logic signed [FRAC_BITS+1:0] cos_r, sin_r;

  logic [31:0] a32, r32;
  logic [1:0]  q_in;
  logic signed [CW-1:0] dx, dy, at_s, xs, ys;
  logic signed [FRAC_BITS+1:0] xf, yf;

  always_comb begin
    a32  = 32'(angle) << (32 - ANGLE_BITS);
    q_in = 2'((a32 + 32'h2000_0000) >> 30);
    r32  = a32 - {q_in, 30'b0};
    dx   = y_r >>> step_r;
    dy   = x_r >>> step_r;
    at_s = $signed({4'b0, pca_pkg::atan_step(step_r)});
    // Round half up to the output fraction, then clamp to plus or minus one.
    xs = (x_r + HALF) >>> SH;
    ys = (y_r + HALF) >>> SH;
    if (xs > ONE) xs = ONE;
    if (xs < NEG_ONE) xs = NEG_ONE;
    if (ys > ONE) ys = ONE;
    if (ys < NEG_ONE) ys = NEG_ONE;
    xf = (FRAC_BITS+2)'(xs);
    yf = (FRAC_BITS+2)'(ys);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == pca_pkg::STEP_W'(pca_pkg::CORDIC_STEPS - 1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= pca_pkg::CORDIC_GAIN;
      y_r <= '0;
      z_r <= CW'($signed(r32));
      q_r <= q_in;
    end else if (run_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at_s;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at_s;
      end
    end
    if (fin_r) begin
      case (q_r)
        2'd0: begin
          cos_r <= xf;
          sin_r <= yf;
        end
        2'd1: begin
          cos_r <= -yf;
          sin_r <= xf;
        end
        2'd2: begin
          cos_r <= -xf;
          sin_r <= -yf;
        end
        default: begin
          cos_r <= yf;
          sin_r <= -xf;
        end
      endcase
    end
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

[rtl/pca_div.sv]
module pca_div #(
  parameter int SUM_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [SUM_BITS-1:0]        dividend,
  input  logic [pca_pkg::DIV_W-1:0]         divisor,
  output logic                              done,
  output logic signed [SUM_BITS-1:0]        quotient
);

  localparam int DW    = pca_pkg::DIV_W;
  localparam int CNT_W = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0] num_r;
  logic [DW-1:0]       rem_r, den_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                neg_r, run_r, done_r;
  logic [DW:0]         trial;
  logic                fits;

  // Restoring division on the magnitude, one quotient bit per cycle.
  always_comb begin
    trial = {rem_r, num_r[SUM_BITS-1]};
    fits  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(SUM_BITS);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_BITS-1];
      num_r <= dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
      rem_r <= '0;
      den_r <= (divisor == '0) ? DW'(1) : divisor;
    end else if (run_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      num_r <= {num_r[SUM_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(num_r) : $signed(num_r);

endmodule

[rtl/plaquette_cosine_accumulator_core.sv]
// U(1) Wilson plaquette averager. Each input word is one lattice site: its x,
// y and t link angles and the six neighbor links that close its three
// plaquettes, as binary angles (2^ANGLE_BITS per turn). The block forms the
// plaquette angles, takes their cosine or sine with TRIG_FRAC_BITS fractional
// bits and adds it into a SUM_BITS running sum: mode 0 adds all three plane
// cosines, mode 1 the xy cosine, mode 2 the xy cosine minus vev, mode 3 the
// xy sine. The site flagged is_last emits one result word and clears the sum;
// in modes 0 and 1 that result is the sum divided by the divisor register
// (truncated toward zero, a divisor of zero counts as one). Every site goes
// through the iterative 30-step CORDIC rotation that all three planes run
// side by side; the last site of a run in modes 0 and 1 also goes through
// the bit-serial divider. A four-entry queue takes sites while the back end
// computes, and the result register lets work go on while a result waits to
// be taken. Configuration takes effect per site as it enters the queue; the
// divisor is read when the division starts.
module plaquette_cosine_accumulator_core #(
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14,
  parameter int SUM_BITS       = 48
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pca_in_if.sink                               in_chan,
  pca_out_if.source                            out_chan,
  input  logic                                 cfg_we,
  input  logic [pca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pca_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int TW    = TRIG_FRAC_BITS + 2;
  localparam int ADD_W = ((TW > pca_pkg::VEV_W) ? TW : pca_pkg::VEV_W) + 2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TRIG = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // Configuration registers.
  pca_pkg::mode_t                      mode_r;
  logic signed [pca_pkg::VEV_W-1:0]    vev_r;
  logic [pca_pkg::DIV_W-1:0]           divisor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= pca_pkg::MODE_ALL_COS;
      vev_r     <= '0;
      divisor_r <= pca_pkg::DIV_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pca_pkg::CFG_MODE:    mode_r    <= pca_pkg::mode_t'(cfg_wdata[1:0]);
        pca_pkg::CFG_VEV:     vev_r     <= $signed(cfg_wdata[pca_pkg::VEV_W-1:0]);
        pca_pkg::CFG_DIVISOR: divisor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: plaquette angles and the queue.
  logic                        q_valid, q_pop;
  logic [2:0][ANGLE_BITS-1:0]  q_angle;
  pca_pkg::pca_ctrl_t          q_ctrl;

  pca_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .mode    (mode_r),
    .vev     (vev_r),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_angle (q_angle),
    .q_ctrl  (q_ctrl)
  );

  // Back end: three CORDIC units, accumulator, divider and result register.
  state_t                      state_r, state_nxt;
  pca_pkg::pca_ctrl_t          ctrl_r;
  logic signed [SUM_BITS-1:0]  run_r, run_nxt;
  logic signed [SUM_BITS-1:0]  res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [pca_pkg::OUT_W-1:0] out_data_r;
  logic                        trig_start, trig_done, div_start, div_done;
  logic signed [TW-1:0]        cos_xy, sin_xy, cos_xt, cos_yt;
  logic signed [ADD_W-1:0]     add_val;
  logic signed [SUM_BITS-1:0]  sum_fin, quot;
  logic                        out_free;

  pca_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_xy (
    .clk(clk), .rst_n(rst_n), .start(trig_start), .angle(q_angle[0]),
    .done(trig_done), .cos_o(cos_xy), .sin_o(sin_xy)
  );
  pca_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_xt (
    .clk(clk), .rst_n(rst_n), .start(trig_start), .angle(q_angle[1]),
    .done(), .cos_o(cos_xt), .sin_o()
  );
  pca_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_yt (
    .clk(clk), .rst_n(rst_n), .start(trig_start), .angle(q_angle[2]),
    .done(), .cos_o(cos_yt), .sin_o()
  );

  pca_div #(.SUM_BITS(SUM_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_fin),
    .divisor(divisor_r), .done(div_done), .quotient(quot)
  );

  // The contribution of one site under the mode it arrived with.
  always_comb begin
    case (ctrl_r.mode)
      pca_pkg::MODE_ALL_COS:
        add_val = ADD_W'(cos_xy) + ADD_W'(cos_xt) + ADD_W'(cos_yt);
      pca_pkg::MODE_XY_COS:
        add_val = ADD_W'(cos_xy);
      pca_pkg::MODE_XY_VEV:
        add_val = ADD_W'(cos_xy) - ADD_W'(ctrl_r.vev);
      default:
        add_val = ADD_W'(sin_xy);
    endcase
    sum_fin = run_r + SUM_BITS'(add_val);
  end

  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    q_pop         = 1'b0;
    trig_start    = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          trig_start = 1'b1;
          state_nxt  = ST_TRIG;
        end
      end
      ST_TRIG: begin
        if (trig_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (!ctrl_r.last) begin
          run_nxt   = sum_fin;
          state_nxt = ST_IDLE;
        end else begin
          run_nxt = '0;
          if (ctrl_r.mode == pca_pkg::MODE_ALL_COS || ctrl_r.mode == pca_pkg::MODE_XY_COS) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            res_nxt   = sum_fin;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = quot;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (q_pop) begin
      ctrl_r <= q_ctrl;
    end
    if (state_r == ST_OUT && out_free) begin
      out_data_r <= pca_pkg::OUT_W'(res_r);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_data_r;

  // The sum is cleared by the site that ends a run.
  a_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && ctrl_r.last) |=> (run_r == '0))
    else $error("running sum not cleared after last site");

  // The divider only finishes while the sequencer waits for it.
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // A new result word only comes from the output state.
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result word raised outside the output state");

  // The CORDIC units are never restarted while a site is in flight.
  a_trig_idle: assert property (@(posedge clk) disable iff (!rst_n)
    trig_start |-> (state_r == ST_IDLE))
    else $error("CORDIC started while busy");

endmodule
